@@ hdl/htfd_pkg.sv @@
// Shared types, constants and functions for the humidity/temperature frame decoder.
// No dependencies; imported by every module of the block.
package htfd_pkg;

    // Receive position inside the six-byte reply
    typedef enum logic [2:0] {
        POS_T_MSB = 3'd0,
        POS_T_LSB = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_MSB = 3'd3,
        POS_H_LSB = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    // Register map (byte address bit 2 selects the register)
    localparam int  REG_AW          = 3;
    localparam logic REG_HUM_FLOOR   = 1'b0;
    localparam logic REG_HUM_CEILING = 1'b1;

    localparam logic [15:0] HUM_FLOOR_RST   = 16'd3145;
    localparam logic [15:0] HUM_CEILING_RST = 16'd55573;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Queue between parser and conversion pipeline
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Scale factors: value = (MUL * word - OFF) / 65535
    localparam logic [30:0] TC_MUL = 31'd17500;
    localparam logic [30:0] TC_OFF = 31'd294907500;
    localparam logic [30:0] TF_MUL = 31'd31500;
    localparam logic [30:0] TF_OFF = 31'd321121500;
    localparam logic [30:0] HP_MUL = 31'd12500;
    localparam logic [30:0] HP_OFF = 31'd39321000;

    // One decoded reply handed from parser to conversion pipeline
    typedef struct packed {
        logic        ok;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
    } job_t;

    typedef struct packed {
        logic               crc_ok;
        logic [15:0]        temp_raw;
        logic [15:0]        hum_raw;
        logic signed [14:0] temp_c_centi;
        logic signed [15:0] temp_f_centi;
        logic [13:0]        hum_centi_pct;
    } result_t;

    // CRC-8, poly 0x31, MSB first, one byte
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // floor(mag / 65535): mag = q*65536 + lo = q*65535 + (q + lo), q + lo < 2*65535
    function automatic logic [15:0] div_full_scale(input logic [30:0] mag);
        logic [14:0] q_est;
        logic [16:0] rem;
        q_est = mag[30:16];
        rem   = {1'b0, mag[15:0]} + {2'b00, q_est};
        return {1'b0, q_est} + ((rem >= 17'd65535) ? 16'd1 : 16'd0);
    endfunction

endpackage

@@ hdl/htfd_front.sv @@
// Byte parser: tracks reply position, runs the CRC-8 and emits one job per reply.
// Depends on htfd_pkg.
module htfd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_accept,
    input  logic [7:0]    rx_byte,
    input  logic          frame_start,
    output logic          push,
    output htfd_pkg::job_t push_job
);
    import htfd_pkg::*;

    pos_t        pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next, crc_in, crc_step;
    logic [7:0]  hold_reg, hold_next;
    logic [15:0] ptemp_reg, ptemp_next;
    logic [15:0] phum_reg, phum_next;
    logic        first_good_reg, first_good_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= POS_T_MSB;
            crc_reg        <= CRC_INIT;
            first_good_reg <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            first_good_reg <= first_good_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg  <= hold_next;
        ptemp_reg <= ptemp_next;
        phum_reg  <= phum_next;
    end

    assign pos_eff  = frame_start ? POS_T_MSB : pos_reg;
    // high bytes always restart the CRC
    assign crc_in   = (pos_eff == POS_T_MSB || pos_eff == POS_H_MSB) ? CRC_INIT : crc_reg;
    assign crc_step = crc_feed(crc_in, rx_byte);

    always_comb begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        hold_next       = hold_reg;
        ptemp_next      = ptemp_reg;
        phum_next       = phum_reg;
        first_good_next = first_good_reg;
        push            = 1'b0;
        push_job.ok        = first_good_reg && (crc_step == 8'h00);
        push_job.temp_word = ptemp_reg;
        push_job.hum_word  = phum_reg;
        if (in_accept) begin
            unique case (pos_eff)
                POS_T_MSB, POS_H_MSB: begin
                    crc_next  = crc_step;
                    hold_next = rx_byte;
                    pos_next  = (pos_eff == POS_T_MSB) ? POS_T_LSB : POS_H_LSB;
                end
                POS_T_LSB: begin
                    crc_next   = crc_step;
                    ptemp_next = {hold_reg, rx_byte};
                    pos_next   = POS_T_CRC;
                end
                POS_H_LSB: begin
                    crc_next  = crc_step;
                    phum_next = {hold_reg, rx_byte};
                    pos_next  = POS_H_CRC;
                end
                POS_T_CRC: begin
                    first_good_next = (crc_step == 8'h00);
                    crc_next        = CRC_INIT;
                    pos_next        = POS_H_MSB;
                end
                POS_H_CRC: begin
                    push     = 1'b1;
                    crc_next = CRC_INIT;
                    pos_next = POS_T_MSB;
                end
                default: begin
                    pos_next = POS_T_MSB;
                end
            endcase
        end
    end

endmodule

@@ hdl/htfd_fifo.sv @@
// Short job queue between the byte parser and the conversion pipeline.
// Depends on htfd_pkg.
module htfd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  htfd_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output htfd_pkg::job_t pop_job,
    output logic           empty
);
    import htfd_pkg::*;

    job_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= Q_AW'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= Q_AW'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_job = mem_reg[rd_ptr_reg];
    assign full    = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);

endmodule

@@ hdl/htfd_back.sv @@
// Conversion pipeline: clamps and latches good words, scales them to centi-units.
// Depends on htfd_pkg; fed from htfd_fifo.
module htfd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [15:0]       hum_floor,
    input  logic [15:0]       hum_ceiling,
    input  logic              job_avail,
    input  htfd_pkg::job_t    job,
    output logic              job_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output htfd_pkg::result_t out_result
);
    import htfd_pkg::*;

    logic        advance;
    logic [15:0] hum_clamped;
    logic [15:0] good_temp_reg, good_hum_reg;

    logic        v1_reg, ok1_reg;
    logic [15:0] t1_reg, h1_reg;

    logic        v2_reg, ok2_reg;
    logic [15:0] t2_reg, h2_reg;
    logic [30:0] pc2_reg, pf2_reg, ph2_reg;

    logic        v3_reg, ok3_reg;
    logic [15:0] t3_reg, h3_reg;
    logic        nc3_reg, nf3_reg, nh3_reg;
    logic [30:0] mc3_reg, mf3_reg, mh3_reg;

    logic        out_valid_reg;
    result_t     res_reg;

    logic [15:0] qc, qf, qh, tc_val, tf_val;

    // whole pipeline moves unless a result is held for the receiver
    assign advance = !out_valid_reg || out_ready;
    assign job_pop = advance && job_avail;

    // floor test first, so a word past both crossed limits gets the floor
    assign hum_clamped = (job.hum_word < hum_floor)   ? hum_floor :
                         (job.hum_word > hum_ceiling) ? hum_ceiling : job.hum_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            good_temp_reg <= '0;
            good_hum_reg  <= '0;
        end else if (advance) begin
            v1_reg        <= job_pop;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
            if (job_pop && job.ok) begin
                good_temp_reg <= job.temp_word;
                good_hum_reg  <= hum_clamped;
            end
        end
    end

    assign qc     = div_full_scale(mc3_reg);
    assign qf     = div_full_scale(mf3_reg);
    assign qh     = div_full_scale(mh3_reg);
    assign tc_val = nc3_reg ? (16'd0 - qc) : qc;
    assign tf_val = nf3_reg ? (16'd0 - qf) : qf;

    always_ff @(posedge aclk) begin
        if (advance) begin
            // stage 1: select the readings reported for this reply
            ok1_reg <= job.ok;
            t1_reg  <= job.ok ? job.temp_word : good_temp_reg;
            h1_reg  <= job.ok ? hum_clamped : good_hum_reg;
            // stage 2: constant products
            ok2_reg <= ok1_reg;
            t2_reg  <= t1_reg;
            h2_reg  <= h1_reg;
            pc2_reg <= 31'(t1_reg) * TC_MUL;
            pf2_reg <= 31'(t1_reg) * TF_MUL;
            ph2_reg <= 31'(h1_reg) * HP_MUL;
            // stage 3: sign and magnitude of numerator
            ok3_reg <= ok2_reg;
            t3_reg  <= t2_reg;
            h3_reg  <= h2_reg;
            nc3_reg <= pc2_reg < TC_OFF;
            nf3_reg <= pf2_reg < TF_OFF;
            nh3_reg <= ph2_reg < HP_OFF;
            mc3_reg <= (pc2_reg < TC_OFF) ? (TC_OFF - pc2_reg) : (pc2_reg - TC_OFF);
            mf3_reg <= (pf2_reg < TF_OFF) ? (TF_OFF - pf2_reg) : (pf2_reg - TF_OFF);
            mh3_reg <= (ph2_reg < HP_OFF) ? (HP_OFF - ph2_reg) : (ph2_reg - HP_OFF);
            // output: divide by full scale, truncate toward zero
            res_reg.crc_ok        <= ok3_reg;
            res_reg.temp_raw      <= t3_reg;
            res_reg.hum_raw       <= h3_reg;
            res_reg.temp_c_centi  <= tc_val[14:0];
            res_reg.temp_f_centi  <= tf_val;
            res_reg.hum_centi_pct <= nh3_reg ? 14'd0 : qh[13:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

endmodule

@@ hdl/humidity_temp_frame_decoder_top.sv @@
// Top level of the humidity/temperature frame decoder: ports, register file, hookup.
// Depends on htfd_pkg, htfd_front, htfd_fifo and htfd_back.
//
// Usage: reply bytes enter on the s_axis channel, one byte per transaction, with
// tuser set on the first byte of a reply. Every sixth byte completes a reply and
// produces one transaction on m_axis: the CRC flag in tuser and the last good raw
// words with their Celsius, Fahrenheit and percent conversions in tdata.
// Throughput: one byte per cycle; a result can leave every cycle.
// After the sixth byte is taken, the result passes the queue write, word select,
// product, magnitude and divide-by-full-scale stages before it is valid.
// When m_axis is stalled the conversion pipeline holds; the 4-entry job queue
// keeps taking bytes until it is full, then s_axis_tready drops.
// Write hum_floor (0x0) and hum_ceiling (0x4) over APB only while idle; the block
// does not enforce this. Reset (aresetn low, synchronous) clears the byte position,
// CRC, queue, pipeline valids and the good readings, and restores the clamp registers.
module humidity_temp_frame_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [htfd_pkg::REG_AW-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // temp_raw, hum_raw, temp_c_centi, temp_f_centi,
                                        // hum_centi_pct, zero pad
    output logic        m_axis_tuser    // [0] crc_ok
);
    import htfd_pkg::*;

    logic [15:0] hum_floor_reg, hum_ceiling_reg;
    logic        cfg_write;
    logic        in_accept;
    logic        push, pop, q_full, q_empty;
    job_t        push_job, pop_job;
    result_t     result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hum_floor_reg   <= HUM_FLOOR_RST;
            hum_ceiling_reg <= HUM_CEILING_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_HUM_FLOOR:   hum_floor_reg   <= pwdata[15:0];
                REG_HUM_CEILING: hum_ceiling_reg <= pwdata[15:0];
                default:         hum_floor_reg   <= hum_floor_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_HUM_CEILING) ? {16'd0, hum_ceiling_reg}
                                                   : {16'd0, hum_floor_reg};

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    htfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .rx_byte     (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .push        (push),
        .push_job    (push_job)
    );

    htfd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    htfd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hum_floor   (hum_floor_reg),
        .hum_ceiling (hum_ceiling_reg),
        .job_avail   (!q_empty),
        .job         (pop_job),
        .job_pop     (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (result)
    );

    assign m_axis_tuser = result.crc_ok;
    assign m_axis_tdata = {3'b000, result.hum_centi_pct, result.temp_f_centi,
                           result.temp_c_centi, result.hum_raw, result.temp_raw};

endmodule

@@ test/htfd_reply_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the humidity/temperature frame decoder: tracks APB writes and
// accepted reply bytes, predicts every result and compares it with m_axis. Uses htfd_pkg.
module htfd_reply_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [htfd_pkg::REG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,
    input  logic                        s_axis_tuser,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [79:0]                 m_axis_tdata,
    input  logic                        m_axis_tuser,
    output int                          mismatches,
    output int                          pending,
    output int                          n_results,
    output int                          n_good
);

    localparam longint FULL_SCALE = 65535;

    logic [15:0]      floor_q, ceil_q;
    htfd_pkg::pos_t   rx_pos;
    logic [7:0]       crc_q, hi_byte;
    logic [15:0]      temp_pend, hum_pend, temp_good, hum_good;
    logic             temp_word_ok;
    int               err_cnt, res_cnt, good_cnt;

    htfd_pkg::result_t expected_readings[$];

    // bit-serial CRC-8, poly 0x31, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[7] ^ b[k];
            c  = {c[6:0], 1'b0};
            if (fb)
                c = c ^ htfd_pkg::CRC_POLY;
        end
        return c;
    endfunction

    // (mul * w - off) / 65535, truncated toward zero
    function automatic longint centi_scale(input longint mul, input longint off,
                                           input logic [15:0] w);
        longint wl;
        wl = w;
        return (mul * wl - off) / FULL_SCALE;
    endfunction

    task automatic decode_reply_byte(input logic [7:0] b, input logic fs);
        htfd_pkg::result_t r;
        logic [15:0]       w;
        logic              good;
        longint            tc, tf, hp;
        if (fs) begin
            rx_pos = htfd_pkg::POS_T_MSB;
            crc_q  = htfd_pkg::CRC_INIT;
        end
        case (rx_pos)
            htfd_pkg::POS_T_MSB, htfd_pkg::POS_H_MSB: begin
                crc_q   = crc8_update(htfd_pkg::CRC_INIT, b);
                hi_byte = b;
                rx_pos  = htfd_pkg::pos_t'(rx_pos + 3'd1);
            end
            htfd_pkg::POS_T_LSB, htfd_pkg::POS_H_LSB: begin
                crc_q = crc8_update(crc_q, b);
                if (rx_pos == htfd_pkg::POS_T_LSB)
                    temp_pend = {hi_byte, b};
                else
                    hum_pend = {hi_byte, b};
                rx_pos = htfd_pkg::pos_t'(rx_pos + 3'd1);
            end
            htfd_pkg::POS_T_CRC: begin
                temp_word_ok = (crc8_update(crc_q, b) == 8'h00);
                crc_q        = htfd_pkg::CRC_INIT;
                rx_pos       = htfd_pkg::POS_H_MSB;
            end
            default: begin
                good   = temp_word_ok && (crc8_update(crc_q, b) == 8'h00);
                crc_q  = htfd_pkg::CRC_INIT;
                rx_pos = htfd_pkg::POS_T_MSB;
                if (good) begin
                    // floor test wins when the clamps are crossed
                    w = hum_pend;
                    if (w < floor_q)
                        w = floor_q;
                    else if (w > ceil_q)
                        w = ceil_q;
                    temp_good = temp_pend;
                    hum_good  = w;
                end
                tc = centi_scale(htfd_pkg::TC_MUL, htfd_pkg::TC_OFF, temp_good);
                tf = centi_scale(htfd_pkg::TF_MUL, htfd_pkg::TF_OFF, temp_good);
                hp = centi_scale(htfd_pkg::HP_MUL, htfd_pkg::HP_OFF, hum_good);
                if (hp < 0)
                    hp = 0;
                r.crc_ok        = good;
                r.temp_raw      = temp_good;
                r.hum_raw       = hum_good;
                r.temp_c_centi  = tc[14:0];
                r.temp_f_centi  = tf[15:0];
                r.hum_centi_pct = hp[13:0];
                expected_readings.push_back(r);
            end
        endcase
    endtask

    task automatic check_result();
        htfd_pkg::result_t got, want;
        got.crc_ok        = m_axis_tuser;
        got.temp_raw      = m_axis_tdata[15:0];
        got.hum_raw       = m_axis_tdata[31:16];
        got.temp_c_centi  = m_axis_tdata[46:32];
        got.temp_f_centi  = m_axis_tdata[62:47];
        got.hum_centi_pct = m_axis_tdata[76:63];
        if (expected_readings.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("[%0t] unexpected result: ok=%0b T=%h H=%h", $realtime,
                         got.crc_ok, got.temp_raw, got.hum_raw);
        end else begin
            want = expected_readings.pop_front();
            res_cnt++;
            if (want.crc_ok)
                good_cnt++;
            if (got.crc_ok !== want.crc_ok || got.temp_raw !== want.temp_raw ||
                got.hum_raw !== want.hum_raw || got.temp_c_centi !== want.temp_c_centi ||
                got.temp_f_centi !== want.temp_f_centi ||
                got.hum_centi_pct !== want.hum_centi_pct) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("[%0t] result mismatch, expected ok=%0b T=%h H=%h C=%0d F=%0d P=%0d",
                             $realtime, want.crc_ok, want.temp_raw, want.hum_raw,
                             want.temp_c_centi, want.temp_f_centi, want.hum_centi_pct);
                    $display("          actual   ok=%0b T=%h H=%h C=%0d F=%0d P=%0d",
                             got.crc_ok, got.temp_raw, got.hum_raw,
                             got.temp_c_centi, got.temp_f_centi, got.hum_centi_pct);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            floor_q      = htfd_pkg::HUM_FLOOR_RST;
            ceil_q       = htfd_pkg::HUM_CEILING_RST;
            rx_pos       = htfd_pkg::POS_T_MSB;
            crc_q        = htfd_pkg::CRC_INIT;
            hi_byte      = '0;
            temp_pend    = '0;
            hum_pend     = '0;
            temp_word_ok = 1'b0;
            temp_good    = '0;
            hum_good     = '0;
            err_cnt      = 0;
            res_cnt      = 0;
            good_cnt     = 0;
            expected_readings.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == htfd_pkg::REG_HUM_FLOOR)
                    floor_q = pwdata[15:0];
                else
                    ceil_q = pwdata[15:0];
            end
            // retire first: an output transaction always belongs to an older byte
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                decode_reply_byte(s_axis_tdata, s_axis_tuser);
        end
        mismatches <= err_cnt;
        pending    <= expected_readings.size();
        n_results  <= res_cnt;
        n_good     <= good_cnt;
    end

endmodule

@@ test/tb_humidity_temp_frame_decoder_top.sv @@
`timescale 1ns / 1ps
// Testbench top for humidity_temp_frame_decoder_top: clock, reset, APB setup, reply
// stimulus and verdict. Depends on htfd_pkg, the RTL and htfd_reply_checker.
module tb_humidity_temp_frame_decoder_top;

    logic                        aclk;
    logic                        aresetn;
    logic                        psel, penable, pwrite;
    logic [htfd_pkg::REG_AW-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        s_axis_tvalid, s_axis_tready;
    logic [7:0]                  s_axis_tdata;
    logic                        s_axis_tuser;
    logic                        m_axis_tvalid, m_axis_tready;
    logic [79:0]                 m_axis_tdata;
    logic                        m_axis_tuser;

    int mismatches, pending, n_results, n_good;
    int bytes_sent, frames_sent;
    int burst_left;
    bit gaps_on;
    int ready_mode;
    int stall_req;

    humidity_temp_frame_decoder_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    htfd_reply_checker i_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending),
        .n_results     (n_results),
        .n_good        (n_good)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    // receiver: own ready pattern, plus a long hold-off on request
    initial begin
        int hold;
        int tick;
        hold = 0;
        tick = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (stall_req > 0) begin
                hold      = stall_req;
                stall_req = 0;
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                case (ready_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(99) < 60);
                    default: m_axis_tready <= ((tick % 8) < 5);
                endcase
            end
        end
    end

    // CRC over one data word, for building replies
    function automatic logic [7:0] word_crc(input logic [15:0] w);
        logic [7:0] c;
        c = htfd_pkg::CRC_INIT;
        for (int k = 15; k >= 0; k--)
            c = (c[7] ^ w[k]) ? ({c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY) : {c[6:0], 1'b0};
        return c;
    endfunction

    function automatic logic [15:0] pick_word(input logic [15:0] lo, input logic [15:0] hi);
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(4000));
            3:       return lo + 16'($urandom_range(6)) - 16'd3;
            4:       return hi + 16'($urandom_range(6)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic fs);
        s_axis_tdata  <= b;
        s_axis_tuser  <= fs;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge aclk);
                burst_left = $urandom_range(12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // flaw: 0 clean, 1 bad temperature CRC, 2 bad humidity CRC, 3 corrupted data byte
    task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input logic fs,
                              input int flaw);
        logic [7:0] tc, hc, flip;
        logic [7:0] t_msb;
        tc    = word_crc(t);
        hc    = word_crc(h);
        flip  = 8'd1 << $urandom_range(7);
        t_msb = t[15:8];
        case (flaw)
            1:       tc    = tc ^ flip;
            2:       hc    = hc ^ flip;
            3:       t_msb = t_msb ^ flip;
            default: ;
        endcase
        push_byte(t_msb, fs);
        push_byte(t[7:0], 1'b0);
        push_byte(tc, 1'b0);
        push_byte(h[15:8], 1'b0);
        push_byte(h[7:0], 1'b0);
        push_byte(hc, 1'b0);
        frames_sent++;
    endtask

    // drain all results, then give the pipeline time to settle before a register write
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_write(input logic sel, input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {16'($urandom), v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // return to idle before the next transfer
        @(posedge aclk);
    endtask

    task automatic random_phase(input int n_items, input logic [15:0] lo, input logic [15:0] hi);
        int start;
        int flaw;
        start = bytes_sent;
        while (bytes_sent - start < n_items) begin
            if ($urandom_range(99) < 8) begin
                // noise: stray bytes, sometimes with a frame start
                repeat ($urandom_range(7, 1))
                    push_byte(8'($urandom), $urandom_range(3) == 0);
            end else begin
                flaw = ($urandom_range(99) < 15) ? $urandom_range(3, 1) : 0;
                send_frame(pick_word(lo, hi), pick_word(lo, hi), $urandom_range(9) < 7, flaw);
            end
        end
    endtask

    initial begin
        logic [15:0] f_rand, c_rand;
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        bytes_sent    = 0;
        frames_sent   = 0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        ready_mode    = 1;
        stall_req     = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset clamps: bad CRC before any good reply, clamp to floor,
        // clamp to ceiling without a frame start, partial reply dropped by a restart
        send_frame(16'h6666, 16'h8000, 1'b1, 2);
        send_frame(16'h0000, 16'h0000, 1'b1, 0);
        send_frame(16'hFFFF, 16'hFFFF, 1'b0, 0);
        push_byte(8'hAA, 1'b1);
        push_byte(8'h55, 1'b0);
        send_frame(16'h1234, 16'h5678, 1'b1, 0);
        wait_idle();

        // open clamps, no idling on either side; negative humidity is clamped to zero at the output
        apb_write(htfd_pkg::REG_HUM_FLOOR, 16'h0000);
        apb_write(htfd_pkg::REG_HUM_CEILING, 16'hFFFF);
        gaps_on    = 1'b0;
        ready_mode = 0;
        send_frame(16'h8000, 16'd100, 1'b1, 0);
        random_phase(170, 16'd3145, 16'd55573);
        wait_idle();

        // crossed clamps, long receiver hold-off to back up the input
        apb_write(htfd_pkg::REG_HUM_FLOOR, 16'hFFFF);
        apb_write(htfd_pkg::REG_HUM_CEILING, 16'h0000);
        gaps_on    = 1'b1;
        ready_mode = 2;
        stall_req  = 200;
        random_phase(170, 16'hFFFF, 16'h0000);
        wait_idle();

        f_rand = 16'($urandom);
        c_rand = 16'($urandom);
        apb_write(htfd_pkg::REG_HUM_FLOOR, f_rand);
        apb_write(htfd_pkg::REG_HUM_CEILING, c_rand);
        ready_mode = 1;
        random_phase(170, f_rand, c_rand);
        wait_idle();

        apb_write(htfd_pkg::REG_HUM_FLOOR, htfd_pkg::HUM_FLOOR_RST);
        apb_write(htfd_pkg::REG_HUM_CEILING, htfd_pkg::HUM_CEILING_RST);
        random_phase(150, htfd_pkg::HUM_FLOOR_RST, htfd_pkg::HUM_CEILING_RST);
        wait_idle();
        repeat (16) @(posedge aclk);

        $display("Sent %0d bytes (%0d built replies) over 5 clamp settings;", bytes_sent,
                 frames_sent);
        $display("checked %0d results, %0d with both CRCs good, %0d mismatches", n_results,
                 n_good, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/htfd_pkg.sv
hdl/htfd_front.sv
hdl/htfd_fifo.sv
hdl/htfd_back.sv
hdl/humidity_temp_frame_decoder_top.sv
test/htfd_reply_checker.sv
test/tb_humidity_temp_frame_decoder_top.sv
